### hdl/cmpp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmpp_pkg
// Shared types, constants and the cosine table generator for the chaotic map
// point projector.
// ----------------------------------------------------------------------------
package cmpp_pkg;

    localparam int WORD_W     = 24;   // map / view word, signed fixed point
    localparam int SCREEN_W   = 16;   // screen coordinate
    localparam int CFG_W      = 12;   // half width / half height
    localparam int CFG_IDX_W  = 1;

    localparam int DEF_COS_ENTRIES = 1024;
    localparam int DEF_FRAC_BITS   = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] HALF_WIDTH_RST  = 12'd512;
    localparam logic [CFG_W-1:0] HALF_HEIGHT_RST = 12'd384;

    localparam longint WORD_MAX   = 64'sd8388607;
    localparam longint WORD_MIN   = -64'sd8388608;
    localparam longint SCREEN_MAX = 64'sd32767;
    localparam longint SCREEN_MIN = -64'sd32768;

    // Q30 series constants
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint PI_Q30  = 64'sd3373259426;
    // 2n(2n-1) and 2n(2n+1), n = 1..7
    localparam longint COS_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};
    localparam longint SIN_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INDEX,
        ST_ROM,
        ST_MAP,
        ST_UPDATE,
        ST_VIEW,
        ST_SUM,
        ST_PROJ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic mul_index;
        logic rd_rom;
        logic mul_map;
        logic upd_state;
        logic mul_view;
        logic add_sum;
        logic mul_proj;
        logic load_out;
    } t_dp_cmd;

    // Entry k of a table of 2^addr_w cosines over one full turn, rounded to
    // frac_bits fraction bits. Evaluated at elaboration only.
    function automatic logic signed [WORD_W-1:0] cos_entry(
        input int k, input int addr_w, input int frac_bits);
        longint m;
        longint quad;
        longint rem;
        longint ang;
        longint x2;
        longint c;
        longint s;
        longint v;
        int     n;
        m    = 4 * longint'(k);
        quad = m >>> addr_w;
        rem  = m & ((longint'(1) << addr_w) - 1);
        ang  = (PI_Q30 * rem) >>> (addr_w + 1);
        x2   = ang * ang / Q30_ONE;
        c    = Q30_ONE;
        s    = Q30_ONE;
        for (n = 7; n >= 1; n--) begin
            c = Q30_ONE - x2 * c / Q30_ONE / COS_DIV[n-1];
            s = Q30_ONE - x2 * s / Q30_ONE / SIN_DIV[n-1];
        end
        s = ang * s / Q30_ONE;
        case (quad)
            0:       v = c;
            1:       v = -s;
            2:       v = -c;
            default: v = s;
        endcase
        v = (v + (longint'(1) << (29 - frac_bits))) >>> (30 - frac_bits);
        return WORD_W'(v);
    endfunction

endpackage
`default_nettype wire

### hdl/cmpp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmpp_ctrl
// Step sequencer and handshake control: walks one item through the datapath
// steps and owns the result valid flag.
// ----------------------------------------------------------------------------
module cmpp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output cmpp_pkg::t_dp_cmd      o_cmd
);
    import cmpp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_INDEX;
                end
            end
            ST_INDEX: begin
                o_cmd.mul_index = 1'b1;
                n_state         = ST_ROM;
            end
            ST_ROM: begin
                o_cmd.rd_rom = 1'b1;
                n_state      = ST_MAP;
            end
            ST_MAP: begin
                o_cmd.mul_map = 1'b1;
                n_state       = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.upd_state = 1'b1;
                n_state         = ST_VIEW;
            end
            ST_VIEW: begin
                o_cmd.mul_view = 1'b1;
                n_state        = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.add_sum = 1'b1;
                n_state       = ST_PROJ;
            end
            ST_PROJ: begin
                o_cmd.mul_proj = 1'b1;
                n_state        = ST_DONE;
            end
            ST_DONE: begin
                // wait here while the previous result is still held
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

### hdl/cmpp_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmpp_dp
// Datapath: map state, cosine ROM, product registers, projection and
// truncate/saturate of the screen coordinates; config registers.
// ----------------------------------------------------------------------------
module cmpp_dp #(
    parameter int COS_TABLE_ENTRIES = cmpp_pkg::DEF_COS_ENTRIES,
    parameter int FRACTION_BITS     = cmpp_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire cmpp_pkg::t_dp_cmd                     i_cmd,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [cmpp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [cmpp_pkg::CFG_W-1:0]            i_cfg_data,
    input  wire logic signed [cmpp_pkg::WORD_W-1:0]    i_map_a,
    input  wire logic signed [cmpp_pkg::WORD_W-1:0]    i_map_c,
    input  wire logic signed [cmpp_pkg::WORD_W-1:0]    i_sin_theta,
    input  wire logic signed [cmpp_pkg::WORD_W-1:0]    i_cos_theta,
    input  wire logic signed [cmpp_pkg::WORD_W-1:0]    i_sin_phi,
    input  wire logic signed [cmpp_pkg::WORD_W-1:0]    i_cos_phi,
    output logic signed [cmpp_pkg::SCREEN_W-1:0]       o_screen_x,
    output logic signed [cmpp_pkg::SCREEN_W-1:0]       o_screen_y
);
    import cmpp_pkg::*;

    localparam int F      = FRACTION_BITS;
    localparam int ADDR_W = $clog2(COS_TABLE_ENTRIES);
    localparam int P_W    = 2 * WORD_W;                       // word x word
    localparam int Q_W    = P_W - F;                          // floored product
    localparam int OMC_W  = ((WORD_W > F + 1) ? WORD_W : F + 1) + 1;
    localparam int PT_W   = OMC_W + WORD_W;
    localparam int T1_W   = PT_W - F;
    localparam int NI_W   = ((T1_W > Q_W) ? T1_W : Q_W) + 1;
    localparam int PV_W   = Q_W + WORD_W;
    localparam int V_W    = PV_W - F;
    localparam int SM_A   = (F + 2 > Q_W) ? F + 2 : Q_W;
    localparam int SUM_W  = ((SM_A > V_W) ? SM_A : V_W) + 2;
    localparam int HALF_W = CFG_W + 1;
    localparam int PR_W   = SUM_W + HALF_W;
    localparam int SC_W   = PR_W - F;
    localparam int IDX_W  = (P_W > 2 * F + 1) ? P_W : 2 * F + 1;
    localparam int IDX_LO = 2 * F + 1 - ADDR_W;

    localparam longint TENTH_L = ((longint'(1) << (F + 1)) + 10) / 20;
    localparam logic signed [WORD_W-1:0] TENTH   = WORD_W'(TENTH_L);
    localparam logic signed [OMC_W-1:0]  ONE_OMC = OMC_W'(longint'(1) << F);
    localparam logic signed [SUM_W-1:0]  ONE_SUM = SUM_W'(longint'(1) << F);
    localparam logic [PR_W-1:0]          TRUNC_BIAS = PR_W'((longint'(1) << F) - 1);

    // cosine ROM, one full turn
    logic signed [WORD_W-1:0] cos_rom [COS_TABLE_ENTRIES];

    for (genvar g = 0; g < COS_TABLE_ENTRIES; g++) begin : g_rom
        assign cos_rom[g] = cos_entry(g, ADDR_W, F);
    end

    // item registers
    logic signed [WORD_W-1:0] r_a, r_c, r_st, r_ct, r_sp, r_cp;
    // map state
    logic signed [WORD_W-1:0] r_i, r_j, r_b;
    // config
    logic [CFG_W-1:0] r_half_w, r_half_h;
    // step registers
    logic signed [P_W-1:0]    r_aj;
    logic signed [Q_W-1:0]    r_ctcp, r_ctsp, r_stcp, r_stsp, r_stj, r_ctj, r_cb;
    logic signed [WORD_W-1:0] r_cos;
    logic signed [T1_W-1:0]   r_t1;
    logic signed [V_W-1:0]    r_xi, r_xb, r_yi, r_yb;
    logic signed [SUM_W-1:0]  r_inx, r_iny;
    logic signed [PR_W-1:0]   r_px, r_py;

    // combinational products
    logic signed [P_W-1:0]    p_ctcp, p_ctsp, p_stcp, p_stsp, p_stj, p_ctj, p_cb;
    logic signed [IDX_W-1:0]  aj_ext;
    logic [ADDR_W-1:0]        rom_idx;
    logic signed [OMC_W-1:0]  omc;
    logic signed [PT_W-1:0]   p_t1;
    logic signed [NI_W-1:0]   ni;
    logic signed [WORD_W-1:0] ni_sat;
    logic signed [PV_W-1:0]   p_xi, p_xb, p_yi, p_yb;
    logic signed [PR_W-1:0]   px_bias, py_bias;
    logic signed [SC_W-1:0]   px_q, py_q;
    logic signed [SCREEN_W-1:0] sx_sat, sy_sat;

    always_comb begin
        p_ctcp = P_W'(r_ct) * P_W'(r_cp);
        p_ctsp = P_W'(r_ct) * P_W'(r_sp);
        p_stcp = P_W'(r_st) * P_W'(r_cp);
        p_stsp = P_W'(r_st) * P_W'(r_sp);
        p_stj  = P_W'(r_st) * P_W'(r_i);      // new j is old i
        p_ctj  = P_W'(r_ct) * P_W'(r_i);
        p_cb   = P_W'(r_c)  * P_W'(r_b);

        // floor(a*j*N / 2^(2F+1)) mod N: plain bit field of the product
        aj_ext  = IDX_W'(r_aj);
        rom_idx = aj_ext[2*F:IDX_LO];

        omc  = ONE_OMC - OMC_W'(r_c);
        p_t1 = PT_W'(omc) * PT_W'(r_cos);

        ni = NI_W'(r_t1) + NI_W'(r_cb);
        if (ni > NI_W'(WORD_MAX)) begin
            ni_sat = WORD_W'(WORD_MAX);
        end else if (ni < NI_W'(WORD_MIN)) begin
            ni_sat = WORD_W'(WORD_MIN);
        end else begin
            ni_sat = ni[WORD_W-1:0];
        end

        p_xi = PV_W'(r_ctcp) * PV_W'(r_i);
        p_xb = PV_W'(r_ctsp) * PV_W'(r_b);
        p_yi = PV_W'(r_stcp) * PV_W'(r_i);
        p_yb = PV_W'(r_stsp) * PV_W'(r_b);

        // divide by 2^F toward zero
        px_bias = r_px + (r_px[PR_W-1] ? TRUNC_BIAS : '0);
        py_bias = r_py + (r_py[PR_W-1] ? TRUNC_BIAS : '0);
        px_q    = px_bias[PR_W-1:F];
        py_q    = py_bias[PR_W-1:F];

        if (px_q > SC_W'(SCREEN_MAX)) begin
            sx_sat = SCREEN_W'(SCREEN_MAX);
        end else if (px_q < SC_W'(SCREEN_MIN)) begin
            sx_sat = SCREEN_W'(SCREEN_MIN);
        end else begin
            sx_sat = px_q[SCREEN_W-1:0];
        end
        if (py_q > SC_W'(SCREEN_MAX)) begin
            sy_sat = SCREEN_W'(SCREEN_MAX);
        end else if (py_q < SC_W'(SCREEN_MIN)) begin
            sy_sat = SCREEN_W'(SCREEN_MIN);
        end else begin
            sy_sat = py_q[SCREEN_W-1:0];
        end
    end

    // map state and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i      <= TENTH;
            r_j      <= TENTH;
            r_b      <= TENTH;
            r_half_w <= HALF_WIDTH_RST;
            r_half_h <= HALF_HEIGHT_RST;
        end else begin
            if (i_cmd.upd_state) begin
                r_j <= r_i;
                r_i <= ni_sat;
                r_b <= r_j;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_HALF_WIDTH:  r_half_w <= i_cfg_data;
                    CFG_HALF_HEIGHT: r_half_h <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_a  <= i_map_a;
            r_c  <= i_map_c;
            r_st <= i_sin_theta;
            r_ct <= i_cos_theta;
            r_sp <= i_sin_phi;
            r_cp <= i_cos_phi;
        end
        if (i_cmd.mul_index) begin
            r_aj   <= P_W'(r_a) * P_W'(r_j);
            r_ctcp <= p_ctcp[P_W-1:F];
            r_ctsp <= p_ctsp[P_W-1:F];
            r_stcp <= p_stcp[P_W-1:F];
            r_stsp <= p_stsp[P_W-1:F];
            r_stj  <= p_stj[P_W-1:F];
            r_ctj  <= p_ctj[P_W-1:F];
            r_cb   <= p_cb[P_W-1:F];
        end
        if (i_cmd.rd_rom) begin
            r_cos <= cos_rom[rom_idx];
        end
        if (i_cmd.mul_map) begin
            r_t1 <= p_t1[PT_W-1:F];
        end
        if (i_cmd.mul_view) begin
            r_xi <= p_xi[PV_W-1:F];
            r_xb <= p_xb[PV_W-1:F];
            r_yi <= p_yi[PV_W-1:F];
            r_yb <= p_yb[PV_W-1:F];
        end
        if (i_cmd.add_sum) begin
            r_inx <= ONE_SUM + SUM_W'(r_stj) + SUM_W'(r_xi) - SUM_W'(r_xb);
            r_iny <= ONE_SUM - SUM_W'(r_ctj) + SUM_W'(r_yi) - SUM_W'(r_yb);
        end
        if (i_cmd.mul_proj) begin
            r_px <= PR_W'($signed({1'b0, r_half_w})) * PR_W'(r_inx);
            r_py <= PR_W'($signed({1'b0, r_half_h})) * PR_W'(r_iny);
        end
        if (i_cmd.load_out) begin
            o_screen_x <= sx_sat;
            o_screen_y <= sy_sat;
        end
    end

endmodule
`default_nettype wire

### hdl/chaotic_map_point_projector.sv
`default_nettype none
// An accepted item walks the index product, cosine ROM read, map products,
//   state update, view products, sums, projection multiply and output load
//   in that order; its result is valid once the output load is done. No new
//   item is taken until then, since the next item uses the new map state.
// A result held in the output register blocks only the final step.
// Reset (synchronous, active low): map terms to 0.1, half sizes to 512 / 384.
// ----------------------------------------------------------------------------
// chaotic_map_point_projector
// Advances a three-term chaotic map one step per item and projects the
// rotated point onto the screen.
// ----------------------------------------------------------------------------
module chaotic_map_point_projector #(
    parameter int COS_TABLE_ENTRIES = cmpp_pkg::DEF_COS_ENTRIES,
    parameter int FRACTION_BITS     = cmpp_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // config write port
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [cmpp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [cmpp_pkg::CFG_W-1:0]            i_cfg_data,
    // input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic signed [cmpp_pkg::WORD_W-1:0]    i_map_a,
    input  wire logic signed [cmpp_pkg::WORD_W-1:0]    i_map_c,
    input  wire logic signed [cmpp_pkg::WORD_W-1:0]    i_sin_theta,
    input  wire logic signed [cmpp_pkg::WORD_W-1:0]    i_cos_theta,
    input  wire logic signed [cmpp_pkg::WORD_W-1:0]    i_sin_phi,
    input  wire logic signed [cmpp_pkg::WORD_W-1:0]    i_cos_phi,
    // output channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [cmpp_pkg::SCREEN_W-1:0]       o_screen_x,
    output logic signed [cmpp_pkg::SCREEN_W-1:0]       o_screen_y
);
    import cmpp_pkg::*;

    // Step commands from the sequencer. Each beat in goes:
    //   load_in -> mul_index (a*j, view cross products, c*b)
    //   -> rd_rom (cos lookup) -> mul_map ((1-c)*cos)
    //   -> upd_state (new i, shift j and b) -> mul_view (products with new i, b)
    //   -> add_sum -> mul_proj (half size x sum) -> load_out (trunc + saturate)
    t_dp_cmd cmd;

    cmpp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Config writes land directly in the datapath; the user must issue them
    // only while no beat is in flight: the block itself does not enforce it.
    cmpp_dp #(
        .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES),
        .FRACTION_BITS     (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_map_a     (i_map_a),
        .i_map_c     (i_map_c),
        .i_sin_theta (i_sin_theta),
        .i_cos_theta (i_cos_theta),
        .i_sin_phi   (i_sin_phi),
        .i_cos_phi   (i_cos_phi),
        .o_screen_x  (o_screen_x),
        .o_screen_y  (o_screen_y)
    );

endmodule
`default_nettype wire

### hdl/cmpp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmpp_checker
// Port-level checks on the projector's handshake timing.
// ----------------------------------------------------------------------------
module cmpp_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  i_in_valid,
    input wire logic                                  o_in_stall,
    input wire logic                                  o_out_valid,
    input wire logic                                  i_out_stall,
    input wire logic signed [cmpp_pkg::SCREEN_W-1:0]  o_screen_x,
    input wire logic signed [cmpp_pkg::SCREEN_W-1:0]  o_screen_y
);
    logic in_beat;

    assign in_beat = i_in_valid && !o_in_stall;

    // busy right after taking a beat
    a_busy_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> o_in_stall)
        else $error("input not stalled after beat");

    // still busy when the result is about to be loaded
    a_busy_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |-> ##8 o_in_stall)
        else $error("input stall dropped before result");

    // a fresh result only appears a fixed time after its beat
    a_result_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_beat, 9))
        else $error("result valid without matching input beat");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_screen_x) && $stable(o_screen_y))
        else $error("stalled result changed");

endmodule

bind chaotic_map_point_projector cmpp_checker u_checker (.*);
`default_nettype wire
